/* hdl/rct_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and the microprogram of the reference count table.
// No dependencies; used by rct_sequencer, rct_datapath and the top level.
package rct_pkg;

   localparam int SLOTS_DEFAULT       = 16;
   localparam int COUNT_WIDTH_DEFAULT = 8;

   localparam int MODE_W   = 2;
   localparam int HANDLE_W = 4;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 16;
   localparam int FCOUNT_W = 5;
   localparam int STEP_W   = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_ASSIGN  = 2'd1,
      MODE_COLLECT = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_CLAMP = 2'd2
   } status_type;

   // datapath action of one step
   typedef enum logic [2:0] {
      ACT_IDLE    = 3'd0,
      ACT_NOP     = 3'd1,
      ACT_CLEAR   = 3'd2,
      ACT_ALLOC   = 3'd3,
      ACT_COLLECT = 3'd4,
      ACT_DEC_OLD = 3'd5,
      ACT_INC_NEW = 3'd6,
      ACT_EMIT    = 3'd7
   } act_type;

   // count memory read address source
   typedef enum logic [1:0] {
      RS_IDX = 2'd0,
      RS_OLD = 2'd1,
      RS_NEW = 2'd2
   } rsel_type;

   // jump conditions
   typedef enum logic [3:0] {
      C_ALWAYS       = 4'd0,
      C_NO_REQ       = 4'd1,
      C_IS_ALLOC     = 4'd2,
      C_IS_ASSIGN    = 4'd3,
      C_IS_COLLECT   = 4'd4,
      C_SAME         = 4'd5,
      C_ALLOC_MORE   = 4'd6,
      C_COLLECT_MORE = 4'd7,
      C_OUT_BUSY     = 4'd8,
      C_NEVER        = 4'd9
   } cond_type;

   typedef struct packed {
      act_type               act;
      rsel_type              rsel;
      cond_type              cond;
      logic [STEP_W-1:0]     target;
   } ucode_type;

   typedef struct packed {
      act_type  act;
      rsel_type rsel;
   } ctrl_type;

   typedef struct packed {
      logic is_alloc;
      logic is_assign;
      logic is_collect;
      logic same;
      logic alloc_more;
      logic collect_more;
   } dp_flags_type;

   localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ALLOC   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_ASSIGN  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_COLLECT = 4'd10;
   localparam logic [STEP_W-1:0] STEP_DONE    = 4'd15;

   function automatic ucode_type uw(input act_type a, input rsel_type r,
                                    input cond_type c, input logic [STEP_W-1:0] t);
      ucode_type w;
      w.act    = a;
      w.rsel   = r;
      w.cond   = c;
      w.target = t;
      return w;
   endfunction

   // Microprogram. A step jumps to target when its condition holds and
   // advances otherwise; the done step wraps around to idle.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         4'd0:    w = uw(ACT_IDLE,    RS_IDX, C_NO_REQ,       STEP_IDLE);
         4'd1:    w = uw(ACT_CLEAR,   RS_IDX, C_IS_ALLOC,     STEP_ALLOC);
         4'd2:    w = uw(ACT_NOP,     RS_IDX, C_IS_ASSIGN,    STEP_ASSIGN);
         4'd3:    w = uw(ACT_NOP,     RS_IDX, C_IS_COLLECT,   STEP_COLLECT);
         4'd4:    w = uw(ACT_NOP,     RS_IDX, C_ALWAYS,       STEP_DONE);
         4'd5:    w = uw(ACT_ALLOC,   RS_IDX, C_ALLOC_MORE,   STEP_ALLOC);
         4'd6:    w = uw(ACT_NOP,     RS_IDX, C_ALWAYS,       STEP_DONE);
         4'd7:    w = uw(ACT_NOP,     RS_OLD, C_SAME,         STEP_DONE);
         4'd8:    w = uw(ACT_DEC_OLD, RS_NEW, C_NEVER,        STEP_IDLE);
         4'd9:    w = uw(ACT_INC_NEW, RS_IDX, C_ALWAYS,       STEP_DONE);
         4'd10:   w = uw(ACT_COLLECT, RS_IDX, C_COLLECT_MORE, STEP_COLLECT);
         4'd11:   w = uw(ACT_NOP,     RS_IDX, C_ALWAYS,       STEP_DONE);
         4'd15:   w = uw(ACT_EMIT,    RS_IDX, C_OUT_BUSY,     STEP_DONE);
         default: w = uw(ACT_NOP,     RS_IDX, C_ALWAYS,       STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

/* hdl/rct_sequencer.sv */
`timescale 1ns / 1ps
// Step counter and microcode table with conditional jumps.
// Depends on rct_pkg.
module rct_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_busy,
   input  rct_pkg::dp_flags_type flags,
   output rct_pkg::ctrl_type     ctrl
);
   import rct_pkg::*;

   logic [STEP_W-1:0] pc_ff;
   logic [STEP_W-1:0] pc_in;
   ucode_type         word;
   logic              taken;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      unique case (word.cond)
         C_ALWAYS:       taken = 1'b1;
         C_NO_REQ:       taken = !req_valid;
         C_IS_ALLOC:     taken = flags.is_alloc;
         C_IS_ASSIGN:    taken = flags.is_assign;
         C_IS_COLLECT:   taken = flags.is_collect;
         C_SAME:         taken = flags.same;
         C_ALLOC_MORE:   taken = flags.alloc_more;
         C_COLLECT_MORE: taken = flags.collect_more;
         C_OUT_BUSY:     taken = out_busy;
         default:        taken = 1'b0;
      endcase
      pc_in = taken ? word.target : pc_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.act  = word.act;
   assign ctrl.rsel = word.rsel;

endmodule

/* hdl/rct_datapath.sv */
`timescale 1ns / 1ps
// Slot table datapath: used marks, count memory, sweep index and result registers.
// Depends on rct_pkg; driven by rct_sequencer control words.
module rct_datapath #(
   parameter int SLOTS       = rct_pkg::SLOTS_DEFAULT,
   parameter int COUNT_WIDTH = rct_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rct_pkg::ctrl_type             ctrl,
   input  logic                          req_valid,
   input  logic [rct_pkg::MODE_W-1:0]    req_mode,
   input  logic [rct_pkg::HANDLE_W-1:0]  req_old_handle,
   input  logic                          req_old_present,
   input  logic [rct_pkg::HANDLE_W-1:0]  req_new_handle,
   input  logic                          req_new_present,
   output rct_pkg::dp_flags_type         flags,
   output logic [rct_pkg::HANDLE_W-1:0]  res_handle,
   output logic [rct_pkg::STATUS_W-1:0]  res_status,
   output logic [rct_pkg::MASK_W-1:0]    res_freed_mask,
   output logic [rct_pkg::FCOUNT_W-1:0]  res_freed_count
);
   import rct_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   logic [MODE_W-1:0]      mode_ff;
   logic [HANDLE_W-1:0]    old_handle_ff, new_handle_ff;
   logic                   old_present_ff, new_present_ff;

   logic [SLOTS-1:0]       used_ff, used_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [HANDLE_W-1:0]    handle_ff, handle_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [MASK_W-1:0]      mask_ff, mask_in;
   logic [FCOUNT_W-1:0]    fcount_ff, fcount_in;

   logic [COUNT_WIDTH-1:0] count_mem [SLOTS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]       rd_addr, wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   wr_en;

   logic [IDX_W-1:0]       old_idx, new_idx;
   logic                   old_ok, new_ok, last;

   assign old_idx = old_handle_ff[IDX_W-1:0];
   assign new_idx = new_handle_ff[IDX_W-1:0];
   // an assign side counts only if present, in range and used
   assign old_ok  = old_present_ff && ({1'b0, old_handle_ff} < (HANDLE_W+1)'(SLOTS))
                    && used_ff[old_idx];
   assign new_ok  = new_present_ff && ({1'b0, new_handle_ff} < (HANDLE_W+1)'(SLOTS))
                    && used_ff[new_idx];
   assign last    = (idx_ff == IDX_W'(SLOTS - 1));

   assign flags.is_alloc     = (mode_ff == MODE_ALLOC);
   assign flags.is_assign    = (mode_ff == MODE_ASSIGN);
   assign flags.is_collect   = (mode_ff == MODE_COLLECT);
   assign flags.same         = old_ok && new_ok && (old_handle_ff == new_handle_ff);
   assign flags.alloc_more   = used_ff[idx_ff] && !last;
   assign flags.collect_more = !last;

   always_comb begin
      used_in   = used_ff;
      idx_in    = idx_ff;
      handle_in = handle_ff;
      status_in = status_ff;
      mask_in   = mask_ff;
      fcount_in = fcount_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_data_ff;
      unique case (ctrl.act)
         ACT_CLEAR: begin
            idx_in    = '0;
            handle_in = '0;
            status_in = STATUS_OK;
            mask_in   = '0;
            fcount_in = '0;
         end
         ACT_ALLOC: begin
            if (!used_ff[idx_ff]) begin
               used_in[idx_ff] = 1'b1;
               wr_en           = 1'b1;
               wr_data         = COUNT_WIDTH'(1);
               handle_in       = HANDLE_W'(idx_ff);
            end else if (last) begin
               status_in = STATUS_FULL;
            end
            idx_in = idx_ff + IDX_W'(1);
         end
         ACT_COLLECT: begin
            if (used_ff[idx_ff] && (rd_data_ff == '0)) begin
               used_in[idx_ff] = 1'b0;
               mask_in         = mask_ff | (MASK_W'(1) << idx_ff);
               fcount_in       = fcount_ff + FCOUNT_W'(1);
            end
            idx_in = idx_ff + IDX_W'(1);
         end
         ACT_DEC_OLD: begin
            if (old_ok) begin
               if (rd_data_ff == '0) begin
                  status_in = STATUS_CLAMP;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = old_idx;
                  wr_data = rd_data_ff - COUNT_WIDTH'(1);
               end
            end
         end
         ACT_INC_NEW: begin
            if (new_ok) begin
               if (rd_data_ff == '1) begin
                  status_in = STATUS_CLAMP;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = new_idx;
                  wr_data = rd_data_ff + COUNT_WIDTH'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (ctrl.rsel)
         RS_OLD:  rd_addr = old_idx;
         RS_NEW:  rd_addr = new_idx;
         default: rd_addr = idx_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= count_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if ((ctrl.act == ACT_IDLE) && req_valid) begin
         mode_ff        <= req_mode;
         old_handle_ff  <= req_old_handle;
         old_present_ff <= req_old_present;
         new_handle_ff  <= req_new_handle;
         new_present_ff <= req_new_present;
      end
      handle_ff <= handle_in;
      status_ff <= status_in;
      mask_ff   <= mask_in;
      fcount_ff <= fcount_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         idx_ff  <= '0;
      end else begin
         used_ff <= used_in;
         idx_ff  <= idx_in;
      end
   end

   assign res_handle      = handle_ff;
   assign res_status      = status_ff;
   assign res_freed_mask  = mask_ff;
   assign res_freed_count = fcount_ff;

endmodule

/* hdl/reference_count_table.sv */
`timescale 1ns / 1ps
// Reference count slot table: allocate, move a reference, collect zero-count slots.
// An allocate probes slots until it finds a free one or reaches the last, an assign is
// shorter when both sides name the same used slot, a collect sweeps every slot, and an
// unknown mode goes straight to the done step. The sequencer returns to the idle step before
// the next accept; the collect sweep reads one slot per cycle from the count memory.
// Synchronous active-high reset clears all used marks at once and holds req_ready low.
module reference_count_table #(
   parameter int SLOTS       = rct_pkg::SLOTS_DEFAULT,
   parameter int COUNT_WIDTH = rct_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rct_pkg::MODE_W-1:0]    req_mode,
   input  logic [rct_pkg::HANDLE_W-1:0]  req_old_handle,
   input  logic                          req_old_present,
   input  logic [rct_pkg::HANDLE_W-1:0]  req_new_handle,
   input  logic                          req_new_present,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rct_pkg::HANDLE_W-1:0]  rsp_handle,
   output logic [rct_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rct_pkg::MASK_W-1:0]    rsp_freed_mask,
   output logic [rct_pkg::FCOUNT_W-1:0]  rsp_freed_count
);
   import rct_pkg::*;

   ctrl_type             ctrl;
   dp_flags_type         flags;
   logic                 out_busy;
   logic                 emit;

   logic [HANDLE_W-1:0]  res_handle;
   logic [STATUS_W-1:0]  res_status;
   logic [MASK_W-1:0]    res_freed_mask;
   logic [FCOUNT_W-1:0]  res_freed_count;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0]  rsp_handle_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [MASK_W-1:0]    rsp_mask_ff;
   logic [FCOUNT_W-1:0]  rsp_count_ff;

   // The sequencer steps through the microprogram; its idle step is the only
   // one that takes a request.
   rct_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .flags     (flags),
      .ctrl      (ctrl)
   );

   rct_datapath #(
      .SLOTS       (SLOTS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_valid       (req_valid),
      .req_mode        (req_mode),
      .req_old_handle  (req_old_handle),
      .req_old_present (req_old_present),
      .req_new_handle  (req_new_handle),
      .req_new_present (req_new_present),
      .flags           (flags),
      .res_handle      (res_handle),
      .res_status      (res_status),
      .res_freed_mask  (res_freed_mask),
      .res_freed_count (res_freed_count)
   );

   // take nothing while reset is held
   assign req_ready = (ctrl.act == ACT_IDLE) && !reset;

   // The output register parts the two sides: a finished result waits here
   // while the next request is accepted and worked on. The done step holds
   // until the register is free, then loads it.
   assign out_busy     = rsp_valid_ff && !rsp_ready;
   assign emit         = (ctrl.act == ACT_EMIT) && !out_busy;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load on emit, hold otherwise
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_handle_ff <= res_handle;
         rsp_status_ff <= res_status;
         rsp_mask_ff   <= res_freed_mask;
         rsp_count_ff  <= res_freed_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_handle      = rsp_handle_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_freed_mask  = rsp_mask_ff;
   assign rsp_freed_count = rsp_count_ff;

`ifndef SYNTHESIS
   // a result appears only from the done step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.act == ACT_EMIT))
      else $error("rsp_valid rose outside the done step");

   // freed count agrees with the freed mask
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($countones(rsp_mask_ff) == 32'(rsp_count_ff)))
      else $error("freed count does not match freed mask");

   // a full table gives handle zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_FULL)) |-> (rsp_handle_ff == '0))
      else $error("nonzero handle with table full");

   // no request is taken while the sequencer is busy with another
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer stayed idle after taking a request");
`endif

endmodule
